>>> hdl/hrpp_pkg.sv
// ----------------------------------------------------------------------------
// Heart rate packet parser package
// Shared constants and the result record passed from the parser to the
// output register.
// ----------------------------------------------------------------------------
package hrpp_pkg;

  localparam int MAX_RR_VALUES_DEF = 7;   // default number of RR intervals kept
  localparam int RR_SHOWN          = 7;   // RR intervals visible at the ports
  localparam int POS_W             = 5;   // width of the byte position counter
  localparam int POS_LIMIT         = 31;  // bytes from this position on are dropped
  localparam int CNT_W             = 3;   // width of the reported RR count

  localparam int FLAG_HR16_BIT     = 0;   // 16-bit heart rate format
  localparam int FLAG_CONTACT_LSB  = 1;   // contact status, two bits
  localparam int FLAG_ENERGY_BIT   = 3;   // energy expended field present

  typedef struct packed {
    logic [15:0]                 heart_rate;
    logic [15:0]                 energy_expended;
    logic [RR_SHOWN-1:0][15:0]   rr_interval;
    logic [1:0]                  contact_status;
    logic [CNT_W-1:0]            rr_count;
  } hrpp_result_t;

endpackage

>>> hdl/hrpp_parser.sv
// ----------------------------------------------------------------------------
// Heart rate packet parser core
// Holds the per-packet field state, decodes the position of each byte and
// builds the result record when the final byte of a packet is taken.
// ----------------------------------------------------------------------------
module hrpp_parser
  import hrpp_pkg::*;
#(
  parameter int MAX_RR_VALUES = MAX_RR_VALUES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         take,
  input  logic [7:0]   byte_value,
  input  logic         last_byte,
  output hrpp_result_t result
);

  localparam int FOUND_W = $clog2(MAX_RR_VALUES + 1);

  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [7:0]         flag_r, flag_nxt;
  logic [15:0]        hr_r, hr_nxt;
  logic [15:0]        energy_r, energy_nxt;
  logic [FOUND_W-1:0] found_r, found_nxt;
  logic [15:0]        rr_store_r [MAX_RR_VALUES];
  logic [15:0]        rr_nxt     [MAX_RR_VALUES];

  logic [POS_W-1:0]   hr_len;
  logic [POS_W-1:0]   rr_base;
  logic [POS_W-1:0]   rr_start;
  logic [POS_W-1:0]   rr_off;
  logic [POS_W-2:0]   rr_idx;
  logic               rr_idx_ok;
  logic [RR_SHOWN-1:0][15:0] shown_rr;
  logic [POS_W-1:0]   cnt_ext;

  assign hr_len    = flag_r[FLAG_HR16_BIT] ? POS_W'(2) : POS_W'(1);
  assign rr_base   = POS_W'(1) + hr_len;
  assign rr_start  = flag_r[FLAG_ENERGY_BIT] ? rr_base + POS_W'(2) : rr_base;
  assign rr_off    = pos_r - rr_start;
  assign rr_idx    = rr_off[POS_W-1:1];
  assign rr_idx_ok = {1'b0, rr_idx} < POS_W'(MAX_RR_VALUES);

  // Field state after the current byte; the result is built from these values.
  always_comb begin
    pos_nxt    = pos_r;
    flag_nxt   = flag_r;
    hr_nxt     = hr_r;
    energy_nxt = energy_r;
    found_nxt  = found_r;
    for (int i = 0; i < MAX_RR_VALUES; i++) begin
      rr_nxt[i] = rr_store_r[i];
    end
    if (pos_r != POS_W'(POS_LIMIT)) begin
      pos_nxt = pos_r + POS_W'(1);
      if (pos_r == '0) begin
        flag_nxt = byte_value;
      end else if (pos_r <= hr_len) begin
        if (pos_r == POS_W'(1)) begin
          hr_nxt = {hr_r[15:8], byte_value};
        end else begin
          hr_nxt = {byte_value, hr_r[7:0]};
        end
      end else if (flag_r[FLAG_ENERGY_BIT] && pos_r == rr_base) begin
        energy_nxt = {energy_r[15:8], byte_value};
      end else if (flag_r[FLAG_ENERGY_BIT] && pos_r == rr_base + POS_W'(1)) begin
        energy_nxt = {byte_value, energy_r[7:0]};
      end else if (rr_idx_ok) begin
        for (int i = 0; i < MAX_RR_VALUES; i++) begin
          if ({1'b0, rr_idx} == POS_W'(i)) begin
            if (!rr_off[0]) begin
              rr_nxt[i] = {8'h00, byte_value};
            end else begin
              rr_nxt[i] = {byte_value, rr_store_r[i][7:0]};
            end
          end
        end
        // An interval counts only once its high byte has arrived.
        if (rr_off[0]) begin
          found_nxt = FOUND_W'({1'b0, rr_idx} + POS_W'(1));
        end
      end
    end
  end

  for (genvar g = 0; g < RR_SHOWN; g++) begin : g_shown
    if (g < MAX_RR_VALUES) begin : g_kept
      assign shown_rr[g] = (POS_W'(g) < POS_W'(found_nxt)) ? rr_nxt[g] : 16'h0000;
    end else begin : g_none
      assign shown_rr[g] = 16'h0000;
    end
  end

  assign cnt_ext = POS_W'(found_nxt);

  always_comb begin
    result.heart_rate      = hr_nxt;
    result.energy_expended = flag_nxt[FLAG_ENERGY_BIT] ? energy_nxt : 16'h0000;
    result.rr_interval     = shown_rr;
    result.contact_status  = flag_nxt[FLAG_CONTACT_LSB +: 2];
    result.rr_count        = (cnt_ext < POS_W'(RR_SHOWN)) ? cnt_ext[CNT_W-1:0]
                                                          : CNT_W'(RR_SHOWN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      flag_r   <= '0;
      hr_r     <= '0;
      energy_r <= '0;
      found_r  <= '0;
    end else if (take) begin
      if (last_byte) begin
        pos_r    <= '0;
        flag_r   <= '0;
        hr_r     <= '0;
        energy_r <= '0;
        found_r  <= '0;
      end else begin
        pos_r    <= pos_nxt;
        flag_r   <= flag_nxt;
        hr_r     <= hr_nxt;
        energy_r <= energy_nxt;
        found_r  <= found_nxt;
      end
    end
  end

  // Stored intervals are only read below the found count, so they need no clearing.
  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < MAX_RR_VALUES; i++) begin
        rr_store_r[i] <= rr_nxt[i];
      end
    end
  end

endmodule

>>> hdl/hrpp_out_reg.sv
// ----------------------------------------------------------------------------
// Heart rate packet parser output register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module hrpp_out_reg
  import hrpp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  hrpp_result_t load_data,
  input  logic         out_stall,
  output logic         out_valid,
  output hrpp_result_t out_data
);

  logic         valid_r, valid_nxt;
  hrpp_result_t data_r;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

>>> hdl/heart_rate_packet_parser.sv
// ----------------------------------------------------------------------------
// Heart rate packet parser
// A final byte waits in the input register until the output register is free; its
// result word is then loaded into the output register and offered from there.
// Throughput: one byte per cycle; the input stalls only while a final byte sits
// in the input register and the output register still holds an untaken result.
// Reset: synchronous, active low; clears the packet state and both valid flags.
// ----------------------------------------------------------------------------
module heart_rate_packet_parser
  import hrpp_pkg::*;
#(
  parameter int MAX_RR_VALUES = MAX_RR_VALUES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_heart_rate,
  output logic [15:0] out_energy_expended,
  output logic [15:0] out_rr_interval_1,
  output logic [15:0] out_rr_interval_2,
  output logic [15:0] out_rr_interval_3,
  output logic [15:0] out_rr_interval_4,
  output logic [15:0] out_rr_interval_5,
  output logic [15:0] out_rr_interval_6,
  output logic [15:0] out_rr_interval_7,
  output logic [1:0]  out_contact_status,
  output logic [2:0]  out_rr_count
);

  logic         s1_valid_r, s1_valid_nxt;
  logic [7:0]   s1_byte_r;
  logic         s1_last_r;
  logic         advance;
  logic         accept_in;
  hrpp_result_t parse_res;
  hrpp_result_t out_res;

  // A non-final byte never needs the output register, so it always moves on.
  assign advance   = s1_valid_r && (!s1_last_r || !out_valid || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign accept_in = in_valid && !in_stall;

  always_comb begin
    if (accept_in) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      s1_byte_r <= in_byte_value;
      s1_last_r <= in_last_byte;
    end
  end

  hrpp_parser #(
    .MAX_RR_VALUES(MAX_RR_VALUES)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (advance),
    .byte_value (s1_byte_r),
    .last_byte  (s1_last_r),
    .result     (parse_res)
  );

  hrpp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && s1_last_r),
    .load_data (parse_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_res)
  );

  assign out_heart_rate      = out_res.heart_rate;
  assign out_energy_expended = out_res.energy_expended;
  assign out_rr_interval_1   = out_res.rr_interval[0];
  assign out_rr_interval_2   = out_res.rr_interval[1];
  assign out_rr_interval_3   = out_res.rr_interval[2];
  assign out_rr_interval_4   = out_res.rr_interval[3];
  assign out_rr_interval_5   = out_res.rr_interval[4];
  assign out_rr_interval_6   = out_res.rr_interval[5];
  assign out_rr_interval_7   = out_res.rr_interval[6];
  assign out_contact_status  = out_res.contact_status;
  assign out_rr_count        = out_res.rr_count;

  // The input side only waits on a final byte blocked by a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_last_r && out_valid && out_stall))
    else $error("input stalled without a blocked final byte");

  // A taken result leaves the output empty unless a final byte moves in.
  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !(s1_valid_r && s1_last_r)) |=> !out_valid)
    else $error("result word repeated");

  // With no complete interval found, the first interval reads as zero.
  a_rr_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rr_count == 3'd0) |-> (out_rr_interval_1 == 16'h0000))
    else $error("interval shown beyond the count");

  // Fewer than seven intervals leave the last field at zero.
  a_rr_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rr_count != 3'd7) |-> (out_rr_interval_7 == 16'h0000))
    else $error("seventh interval shown beyond the count");

endmodule

>>> test/hrpp_checker.sv
// ----------------------------------------------------------------------------
// Heart rate packet parser checker
// Watches the byte and result channels, predicts each result word from the
// accepted bytes and compares every field against the oldest prediction.
// ----------------------------------------------------------------------------
module hrpp_checker
  import hrpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_heart_rate,
  input  logic [15:0] out_energy_expended,
  input  logic [15:0] out_rr_interval_1,
  input  logic [15:0] out_rr_interval_2,
  input  logic [15:0] out_rr_interval_3,
  input  logic [15:0] out_rr_interval_4,
  input  logic [15:0] out_rr_interval_5,
  input  logic [15:0] out_rr_interval_6,
  input  logic [15:0] out_rr_interval_7,
  input  logic [1:0]  out_contact_status,
  input  logic [2:0]  out_rr_count,
  output int          mismatches,
  output int          pending,
  output int          checked
);

  // Packet state of the prediction, cleared after every final byte.
  int          seen_bytes;
  logic [7:0]  flags_q;
  logic [15:0] rate_q;
  logic [15:0] energy_q;
  logic [15:0] rr_vals [MAX_RR_VALUES_DEF];
  int          rr_done;

  hrpp_result_t expected_reports [$];
  hrpp_result_t want;
  logic [15:0]  got_rr [RR_SHOWN];

  initial begin
    mismatches = 0;
    pending    = 0;
    checked    = 0;
  end

  task automatic report_error(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int exp_val);
    if (got != exp_val)
      report_error($sformatf("%s got 0x%0h, want 0x%0h", name, got, exp_val));
  endtask

  task automatic clear_packet();
    seen_bytes = 0;
    flags_q    = '0;
    rate_q     = '0;
    energy_q   = '0;
    rr_done    = 0;
    foreach (rr_vals[i]) rr_vals[i] = '0;
  endtask

  // Folds one accepted byte into the packet state; a final byte queues the
  // result word the parser must produce.
  task automatic absorb_byte(input logic [7:0] b, input logic last);
    int           p;
    int           hr_len;
    int           rr_base;
    int           k;
    hrpp_result_t r;
    if (seen_bytes < POS_LIMIT) begin
      p = seen_bytes;
      seen_bytes++;
      if (p == 0) begin
        flags_q = b;
      end else begin
        hr_len  = flags_q[FLAG_HR16_BIT] ? 2 : 1;
        rr_base = 1 + hr_len;
        if (p <= hr_len) begin
          if (p == 1) rate_q[7:0] = b;
          else rate_q[15:8] = b;
        end else if (flags_q[FLAG_ENERGY_BIT] && p == rr_base) begin
          energy_q[7:0] = b;
        end else if (flags_q[FLAG_ENERGY_BIT] && p == rr_base + 1) begin
          energy_q[15:8] = b;
        end else begin
          if (flags_q[FLAG_ENERGY_BIT]) rr_base += 2;
          k = (p - rr_base) / 2;
          if (k < MAX_RR_VALUES_DEF) begin
            // An interval only counts once its high byte has arrived.
            if (((p - rr_base) % 2) == 0) begin
              rr_vals[k] = {8'h00, b};
            end else begin
              rr_vals[k][15:8] = b;
              rr_done = k + 1;
            end
          end
        end
      end
    end
    if (last) begin
      r.heart_rate      = rate_q;
      r.energy_expended = flags_q[FLAG_ENERGY_BIT] ? energy_q : 16'h0000;
      for (int i = 0; i < RR_SHOWN; i++)
        r.rr_interval[i] = (i < rr_done && i < MAX_RR_VALUES_DEF) ? rr_vals[i] : 16'h0000;
      r.contact_status = flags_q[FLAG_CONTACT_LSB +: 2];
      r.rr_count       = CNT_W'((rr_done < RR_SHOWN) ? rr_done : RR_SHOWN);
      expected_reports.push_back(r);
      clear_packet();
    end
  endtask

  initial clear_packet();

  always @(posedge clk) begin
    if (rst_n) begin
      // Results are checked before the byte of this edge is absorbed: a
      // result never leaves in the same cycle as its final byte.
      if (out_valid && !out_stall) begin
        checked++;
        if (expected_reports.size() == 0) begin
          report_error("result word arrived with none expected");
        end else begin
          want      = expected_reports.pop_front();
          got_rr[0] = out_rr_interval_1;
          got_rr[1] = out_rr_interval_2;
          got_rr[2] = out_rr_interval_3;
          got_rr[3] = out_rr_interval_4;
          got_rr[4] = out_rr_interval_5;
          got_rr[5] = out_rr_interval_6;
          got_rr[6] = out_rr_interval_7;
          check_field("heart_rate", out_heart_rate, want.heart_rate);
          check_field("energy_expended", out_energy_expended, want.energy_expended);
          for (int i = 0; i < RR_SHOWN; i++)
            check_field($sformatf("rr_interval_%0d", i + 1), got_rr[i],
                        want.rr_interval[i]);
          check_field("contact_status", out_contact_status, want.contact_status);
          check_field("rr_count", out_rr_count, want.rr_count);
        end
      end
      if (in_valid && !in_stall) absorb_byte(in_byte_value, in_last_byte);
      pending = expected_reports.size();
    end
  end

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// Heart rate packet parser testbench
// Feeds directed and random measurement packets byte by byte with random
// gaps and random result stalls; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

  localparam int BYTE_TARGET = 1050;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte_value;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_heart_rate;
  logic [15:0] out_energy_expended;
  logic [15:0] out_rr_interval_1;
  logic [15:0] out_rr_interval_2;
  logic [15:0] out_rr_interval_3;
  logic [15:0] out_rr_interval_4;
  logic [15:0] out_rr_interval_5;
  logic [15:0] out_rr_interval_6;
  logic [15:0] out_rr_interval_7;
  logic [1:0]  out_contact_status;
  logic [2:0]  out_rr_count;

  int mismatches;
  int pending;
  int checked;
  int cycles;
  int bytes_sent;
  int packets_sent;
  bit calm;

  logic [7:0] pkt [$];

  heart_rate_packet_parser dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_byte_value       (in_byte_value),
    .in_last_byte        (in_last_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_heart_rate      (out_heart_rate),
    .out_energy_expended (out_energy_expended),
    .out_rr_interval_1   (out_rr_interval_1),
    .out_rr_interval_2   (out_rr_interval_2),
    .out_rr_interval_3   (out_rr_interval_3),
    .out_rr_interval_4   (out_rr_interval_4),
    .out_rr_interval_5   (out_rr_interval_5),
    .out_rr_interval_6   (out_rr_interval_6),
    .out_rr_interval_7   (out_rr_interval_7),
    .out_contact_status  (out_contact_status),
    .out_rr_count        (out_rr_count)
  );

  hrpp_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_byte_value       (in_byte_value),
    .in_last_byte        (in_last_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_heart_rate      (out_heart_rate),
    .out_energy_expended (out_energy_expended),
    .out_rr_interval_1   (out_rr_interval_1),
    .out_rr_interval_2   (out_rr_interval_2),
    .out_rr_interval_3   (out_rr_interval_3),
    .out_rr_interval_4   (out_rr_interval_4),
    .out_rr_interval_5   (out_rr_interval_5),
    .out_rr_interval_6   (out_rr_interval_6),
    .out_rr_interval_7   (out_rr_interval_7),
    .out_contact_status  (out_contact_status),
    .out_rr_count        (out_rr_count),
    .mismatches          (mismatches),
    .pending             (pending),
    .checked             (checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_byte_value <= b;
    in_last_byte  <= last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_packet();
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
    packets_sent++;
  endtask

  task automatic push_random(input int n);
    repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
  endtask

  // Mostly well-formed packets with random content; the rest are cut short,
  // pure noise, or long, most of them running past the position limit.
  task automatic build_random_packet();
    int         kind;
    int         len;
    logic [7:0] fl;
    pkt.delete();
    kind = $urandom_range(0, 19);
    fl   = 8'($urandom_range(0, 255));
    pkt.push_back(fl);
    if (kind < 16) begin
      push_random(fl[0] ? 2 : 1);
      if (fl[3]) push_random(2);
      push_random(2 * $urandom_range(0, 9));
      if ($urandom_range(0, 4) == 0) push_random(1);
      if (kind >= 14) begin
        len = $urandom_range(1, pkt.size());
        pkt = pkt[0:len-1];
      end
    end else if (kind < 18) begin
      push_random($urandom_range(0, 9));
    end else begin
      push_random($urandom_range(29, 39));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Result side: before each word, hold stall across a random number of
  // cycles in which a word is actually offered.
  initial begin
    int gap;
    int held;
    out_stall = 1'b0;
    forever begin
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        out_stall <= 1'b1;
        held = 0;
        while (held < gap) begin
          @(posedge clk);
          if (out_valid) held++;
          @(negedge clk);
        end
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_byte_value = 8'h00;
    in_last_byte  = 1'b0;
    cycles        = 0;
    bytes_sent    = 0;
    packets_sent  = 0;
    calm          = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Flags-only packets, with no bits and with every bit set.
    pkt = '{8'h00};
    send_packet();
    pkt = '{8'hff};
    send_packet();
    // 16-bit heart rate at its maximum.
    pkt = '{8'h01, 8'hff, 8'hff};
    send_packet();
    // Zero 8-bit rate, maximum energy, one interval.
    pkt = '{8'h08, 8'h00, 8'hff, 8'hff, 8'h34, 8'h12};
    send_packet();
    // Contact bits and the ignored RR flag, one interval plus an odd byte.
    pkt = '{8'h16, 8'h50, 8'hcd, 8'hab, 8'h77};
    send_packet();
    // Short packet: the energy word is missing its high byte.
    pkt = '{8'h09, 8'h10, 8'h00, 8'h20};
    send_packet();

    // Let every result drain before the random part starts.
    wait_drained();

    while (bytes_sent < BYTE_TARGET) begin
      build_random_packet();
      calm = ($urandom_range(0, 7) == 0);
      send_packet();
      if (packets_sent == 50) wait_drained();
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Sent %0d bytes in %0d packets: flag mixes, short, noisy and over-long.",
             bytes_sent, packets_sent);
    $display("Compared %0d result words field by field; %0d mismatches.",
             checked, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
